// File: hdl/itoa_fmt_pkg.sv
// Shared types, constants and the hex character helper for the integer-to-ASCII formatter.
package itoa_fmt_pkg;

    localparam int VALUE_W    = 32;
    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_MAX = 10;
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int DCNT_W     = $clog2(DIGITS_MAX + 1);
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int PROD_W     = 2 * VALUE_W;

    localparam logic [REQ_W-1:0] REQ_BIN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CHAR_B     = 7'h62;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;

    // Multiplying by this and shifting right by DIV10_SHIFT divides any 32-bit value by ten.
    localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0,
        ST_B1,
        ST_SKIP,
        ST_BITS,
        ST_X0,
        ST_X1,
        ST_HEX,
        ST_DIV,
        ST_REM,
        ST_DEC
    } state_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_B,
        SEL_X,
        SEL_BIT,
        SEL_HEX,
        SEL_DEC
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        char_sel_t sel;
        logic      last;
        logic      bin_shift;
        logic      hex_shift;
        logic      div_step;
        logic      dig_push;
        logic      dec_pop;
    } ctl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic msb;
        logic cnt_one;
        logic quot_zero;
        logic dig_nine;
        logic dig_one;
    } ctl_stat_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < DIGIT_W'(10))
        begin
            c = CHAR_ZERO + CHAR_W'(nib);
        end
        else
        begin
            c = CHAR_LOW_A + CHAR_W'(nib - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

// File: hdl/itoa_fmt_ctrl.sv
// Controller state machine that sequences prefix, leading-zero skip, divide-by-ten steps and character beats.
module itoa_fmt_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [itoa_fmt_pkg::REQ_W-1:0]  req_type,
    output logic                            in_ready,
    input  itoa_fmt_pkg::ctl_stat_t         stat,
    output itoa_fmt_pkg::ctl_cmd_t          cmd
);
    import itoa_fmt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = SEL_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_BIN: state_next = ST_B0;
                        REQ_DEC: state_next = ST_DIV;
                        REQ_HEX: state_next = ST_X0;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B0, ST_X0:
            begin
                cmd.sel = SEL_ZERO;
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = (state_reg == ST_B0) ? ST_B1 : ST_X1;
                end
            end
            ST_B1:
            begin
                cmd.sel = SEL_B;
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_SKIP;
                end
            end
            ST_X1:
            begin
                cmd.sel = SEL_X;
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_HEX;
                end
            end
            ST_SKIP:
            begin
                if (!stat.msb && !stat.cnt_one)
                begin
                    cmd.bin_shift = 1'b1;
                end
                else
                begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                cmd.sel  = SEL_BIT;
                cmd.last = stat.cnt_one;
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.bin_shift = 1'b1;
                    if (stat.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HEX:
            begin
                cmd.sel  = SEL_HEX;
                cmd.last = stat.cnt_one;
                if (stat.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.hex_shift = 1'b1;
                    if (stat.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.dig_push = 1'b1;
                if (stat.quot_zero || stat.dig_nine)
                begin
                    state_next = ST_DEC;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DEC:
            begin
                cmd.sel  = SEL_DEC;
                cmd.last = stat.dig_one;
                if (stat.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.dec_pop = 1'b1;
                    if (stat.dig_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/itoa_fmt_dp.sv
// Datapath: value shifter, reciprocal divide by ten, digit stack and output register.
module itoa_fmt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [itoa_fmt_pkg::REQ_W-1:0]    req_type,
    input  logic [itoa_fmt_pkg::VALUE_W-1:0]  value,
    input  itoa_fmt_pkg::ctl_cmd_t            cmd,
    output itoa_fmt_pkg::ctl_stat_t           stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [itoa_fmt_pkg::CHAR_W-1:0]   out_char,
    output logic                              out_last
);
    import itoa_fmt_pkg::*;

    logic [VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] quot_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [DIGIT_W-1:0] dig_reg [DIGITS_MAX];
    logic               valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [PROD_W-1:0]  prod;
    logic [DIGIT_W-1:0] rem_dig;
    logic [CHAR_W-1:0]  char_next;

    // The remainder is below ten, so only the low four bits of value - 10 * quotient matter.
    assign prod    = PROD_W'(val_reg) * PROD_W'(DIV10_MAGIC);
    assign rem_dig = val_reg[DIGIT_W-1:0] - {quot_reg[0], 3'b000} - {quot_reg[2:0], 1'b0};

    assign stat.slot_free = !valid_reg || out_ready;
    assign stat.msb       = val_reg[VALUE_W-1];
    assign stat.cnt_one   = (cnt_reg == CNT_W'(1));
    assign stat.quot_zero = (quot_reg == '0);
    assign stat.dig_nine  = (dcnt_reg == DCNT_W'(DIGITS_MAX - 1));
    assign stat.dig_one   = (dcnt_reg == DCNT_W'(1));

    always_comb
    begin
        case (cmd.sel)
            SEL_ZERO: char_next = CHAR_ZERO;
            SEL_B:    char_next = CHAR_B;
            SEL_X:    char_next = CHAR_X;
            SEL_BIT:  char_next = val_reg[VALUE_W-1] ? CHAR_ONE : CHAR_ZERO;
            SEL_HEX:  char_next = hex_char(val_reg[VALUE_W-1 -: DIGIT_W]);
            SEL_DEC:  char_next = CHAR_ZERO + CHAR_W'(dig_reg[0]);
            default:  char_next = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg  <= value;
            cnt_reg  <= (req_type == REQ_HEX) ? CNT_W'(HEX_DIGITS) : CNT_W'(VALUE_W);
            dcnt_reg <= '0;
        end
        else if (cmd.bin_shift)
        begin
            val_reg <= {val_reg[VALUE_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.hex_shift)
        begin
            val_reg <= {val_reg[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.div_step)
        begin
            quot_reg <= VALUE_W'(prod >> DIV10_SHIFT);
        end
        else if (cmd.dig_push)
        begin
            val_reg    <= quot_reg;
            dcnt_reg   <= dcnt_reg + DCNT_W'(1);
            dig_reg[0] <= rem_dig;
            for (int i = 1; i < DIGITS_MAX; i++)
            begin
                dig_reg[i] <= dig_reg[i-1];
            end
        end
        else if (cmd.dec_pop)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
            for (int i = 0; i < DIGITS_MAX - 1; i++)
            begin
                dig_reg[i] <= dig_reg[i+1];
            end
        end
        if (cmd.emit)
        begin
            char_reg <= char_next;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// File: hdl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: controller, datapath and stream ports.
//
//  Channel   Dir  Payload                                   Beat
//  s_axis    in   tdata[31:0] value, tuser[1:0] req_type    one number
//  m_axis    out  tdata[6:0] ascii_char, tlast last_char    one character
//
// Hex emits the 0x prefix and then all eight hex digits, 10 characters.
// Binary emits the 0b prefix, skips leading zeros one bit at a time, then emits each remaining digit.
// Decimal divides by ten with a reciprocal multiply, in a divide step and a remainder step per
// digit, then emits the stacked digits.
// A new number is accepted only after the last character is handed to the output register.
// Output stalls hold the output register and pause the emitting states; reset clears the
// state machine and output valid.
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic        m_axis_tlast
);
    import itoa_fmt_pkg::*;

    ctl_cmd_t          cmd;
    ctl_stat_t         stat;
    logic [CHAR_W-1:0] out_char;

    itoa_fmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .req_type (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itoa_fmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (s_axis_tuser),
        .value     (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// File: hdl/itoa_fmt_checker.sv
// Port-level checker for the integer-to-ASCII formatter and its bind.
module itoa_fmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import itoa_fmt_pkg::*;

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("character beat has bit 7 set");

    a_busy_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready while a number is still being emitted");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_BIN || s_axis_tuser == REQ_DEC
            || s_axis_tuser == REQ_HEX)) |=> !s_axis_tready)
        else $error("input ready right after accepting a valid format request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind integer_to_ascii_formatter itoa_fmt_checker u_itoa_fmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/integer_to_ascii_formatter_test.sv
// Testbench that streams numbers into the formatter and checks every character it emits.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
    import itoa_fmt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_NUMBERS = 250;
    localparam int PHASES = 5;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last_char;
    } text_beat_t;

    class text_scoreboard;
        text_beat_t expected_text[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note_number(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] val);
            logic [CHAR_W-1:0]  chars[$];
            logic [VALUE_W-1:0] rest;
            logic [3:0]         nib;
            int                 top;
            text_beat_t         beat;
            case (kind)
                REQ_BIN:
                begin
                    chars.push_back(CHAR_ZERO);
                    chars.push_back(CHAR_B);
                    top = VALUE_W - 1;
                    while (top > 0 && !val[top])
                        top--;
                    for (int i = top; i >= 0; i--)
                        chars.push_back(val[i] ? CHAR_ONE : CHAR_ZERO);
                end
                REQ_DEC:
                begin
                    rest = val;
                    do
                    begin
                        chars.push_front(CHAR_ZERO + CHAR_W'(rest % 10));
                        rest = rest / 10;
                    end
                    while (rest != 0);
                end
                REQ_HEX:
                begin
                    chars.push_back(CHAR_ZERO);
                    chars.push_back(CHAR_X);
                    for (int i = 7; i >= 0; i--)
                    begin
                        nib = val[i*4 +: 4];
                        chars.push_back(nib < 10 ? CHAR_ZERO + CHAR_W'(nib)
                                                 : CHAR_LOW_A + CHAR_W'(nib - 10));
                    end
                end
                default:
                begin
                end
            endcase
            foreach (chars[i])
            begin
                beat.ascii_char = chars[i];
                beat.last_char  = (i == chars.size() - 1);
                expected_text.push_back(beat);
            end
        endfunction

        function void check_char(input logic [7:0] data, input logic last);
            text_beat_t want;
            if (expected_text.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual data %h last %b",
                         $time, data, last);
                return;
            end
            want = expected_text.pop_front();
            if (data !== {1'b0, want.ascii_char})
            begin
                errors++;
                $display("%0t: character mismatch, expected %h, actual %h",
                         $time, {1'b0, want.ascii_char}, data);
            end
            if (last !== want.last_char)
            begin
                errors++;
                $display("%0t: last flag mismatch, expected %b, actual %b",
                         $time, want.last_char, last);
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void check_drained();
            if (expected_text.size() != 0)
            begin
                errors += expected_text.size();
                $display("%0t: %0d characters expected but never received, expected %h, actual none",
                         $time, expected_text.size(), expected_text[0].ascii_char);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    bit no_idle = 1'b0;
    text_scoreboard board = new();

    integer_to_ascii_formatter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_number(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= val;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_number(kind, val);
    endtask

    task automatic take_char();
        int stall;
        stall = no_idle ? 0 : $urandom_range(0, 15);
        if (stall > 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        do
            @(posedge clk);
        while (!m_axis_tvalid);
        board.check_char(m_axis_tdata, m_axis_tlast);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] val;
        case ($urandom_range(0, 4))
            0:       val = $urandom;
            1:       val = $urandom_range(0, 15);
            2:       val = $urandom_range(0, 99999);
            3:       val = 32'h1 << $urandom_range(0, 31);
            default: val = $urandom >> $urandom_range(0, 31);
        endcase
        return val;
    endfunction

    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
            take_char();
    end

    initial
    begin
        int                 counted;
        logic [REQ_W-1:0]   kind;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_BIN;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_number(REQ_BIN, 32'h0000_0000);
        send_number(REQ_BIN, 32'h0000_0001);
        send_number(REQ_BIN, 32'h0000_0005);
        send_number(REQ_BIN, 32'h8000_0000);
        send_number(REQ_BIN, 32'hFFFF_FFFF);
        send_number(REQ_DEC, 32'd0);
        send_number(REQ_DEC, 32'd9);
        send_number(REQ_DEC, 32'd10);
        send_number(REQ_DEC, 32'd999_999_999);
        send_number(REQ_DEC, 32'd1_000_000_000);
        send_number(REQ_DEC, 32'hFFFF_FFFF);
        send_number(REQ_UNUSED, 32'h1234_5678);
        send_number(REQ_HEX, 32'h0000_0000);
        send_number(REQ_HEX, 32'hFFFF_FFFF);
        send_number(REQ_HEX, 32'h0123_4567);
        send_number(REQ_HEX, 32'h89AB_CDEF);
        send_number(REQ_UNUSED, 32'hFFFF_FFFF);
        send_number(REQ_HEX, 32'hDEAD_BEEF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            no_idle = (phase == 1);
            counted = 0;
            while (counted < RANDOM_NUMBERS / PHASES)
            begin
                if ($urandom_range(0, 15) == 0)
                    kind = REQ_UNUSED;
                else
                    case ($urandom_range(0, 2))
                        0:       kind = REQ_BIN;
                        1:       kind = REQ_DEC;
                        default: kind = REQ_HEX;
                    endcase
                send_number(kind, random_value());
                if (kind != REQ_UNUSED)
                    counted++;
            end
            if (phase == 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end

        no_idle = 1'b0;
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.check_drained();
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
hdl/itoa_fmt_pkg.sv
hdl/itoa_fmt_ctrl.sv
hdl/itoa_fmt_dp.sv
hdl/integer_to_ascii_formatter.sv
hdl/itoa_fmt_checker.sv
verif/integer_to_ascii_formatter_test.sv
